// File: src/pnu_pkg.sv
// Shared constants and types for the polyline unit normal stream core.
`default_nettype none

package pnu_pkg;

	// Field widths
	localparam int COORD_WIDTH      = 24;
	localparam int NORMAL_FRAC_BITS = 15;
	localparam int OUT_WIDTH        = 16;

	// Stream packing
	localparam int S_TDATA_BITS  = 2 * COORD_WIDTH;
	localparam int S_TDATA_WIDTH = ((S_TDATA_BITS + 7) / 8) * 8;
	localparam int M_TDATA_BITS  = 2 * OUT_WIDTH;
	localparam int M_TDATA_WIDTH = ((M_TDATA_BITS + 7) / 8) * 8;

	// Magnitude of a neighbor difference can reach 2^COORD_WIDTH - 1
	localparam int MAG_WIDTH = COORD_WIDTH + 1;

	// The larger normalized magnitude lies in [2^30, 2^31)
	localparam int NORM_BITS     = 31;
	localparam int NIN_WIDTH     = (MAG_WIDTH > NORM_BITS) ? MAG_WIDTH : NORM_BITS;
	localparam int SUM_WIDTH     = 2 * NORM_BITS + 1;
	localparam int MUL_CNT_WIDTH = $clog2(NORM_BITS);

	// Square root works on a 64-bit radicand, giving a 32-bit root
	localparam int ROOT_BITS  = 32;
	localparam int SQRT_WIDTH = 2 * ROOT_BITS;

	// Divider: quotient never exceeds 2^NORMAL_FRAC_BITS
	localparam int QUO_WIDTH     = NORMAL_FRAC_BITS + 1;
	localparam int DIV_WIDTH     = ROOT_BITS + NORMAL_FRAC_BITS + 1;
	localparam int DIV_CNT_WIDTH = $clog2(QUO_WIDTH);

	// Saturation limits of the Q1.F components
	localparam int ONE_INT     = 1 << NORMAL_FRAC_BITS;
	localparam int POS_CAP_INT = (ONE_INT < 32767) ? ONE_INT : 32767;
	localparam int NEG_CAP_INT = (ONE_INT < 32768) ? ONE_INT : 32768;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] normal_x;
		logic signed [OUT_WIDTH-1:0] normal_y;
		logic                        degenerate;
		logic                        last_normal;
	} result_t;

endpackage

`default_nettype wire

// File: src/polyline_unit_normal_stream_core.sv
// A zero normal passes through the pending result register and the emit state to the output register.
// An interior normal passes through the normalizing shifts, 31 serial square steps, 32 square-root
// steps and 16 divide steps before it reaches the pending result register and the emit state.
// One point is in work at a time; a new point is taken once the prior results are queued.
// The output register holds one result, so input is taken while a result waits.
// Reset (arst_n low, asynchronous) empties the point history and drops any pending result.
`default_nettype none

module polyline_unit_normal_stream_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// point_x [23:0], point_y [47:24]
	input  wire logic [pnu_pkg::S_TDATA_WIDTH-1:0] s_tdata,
	// last_point
	input  wire logic                              s_tlast,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// normal_x [15:0], normal_y [31:16]
	output logic [pnu_pkg::M_TDATA_WIDTH-1:0]      m_tdata,
	// degenerate
	output logic                                   m_tuser,
	// last_normal
	output logic                                   m_tlast
);
	import pnu_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MAG  = 5'b00010,
		ST_ROOT = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	localparam logic [1:0] SEEN_NONE = 2'd0;
	localparam logic [1:0] SEEN_ONE  = 2'd1;
	localparam logic [1:0] SEEN_TWO  = 2'd2;

	localparam int MAG_OUT_WIDTH = OUT_WIDTH + 1;
	localparam logic [QUO_WIDTH-1:0] POS_CAP = QUO_WIDTH'(POS_CAP_INT);
	localparam logic [QUO_WIDTH-1:0] NEG_CAP = QUO_WIDTH'(NEG_CAP_INT);
	localparam result_t ZERO_LAST = '{normal_x: '0, normal_y: '0, degenerate: 1'b0,
		last_normal: 1'b1};

	state_t                        state_q;
	logic [1:0]                    seen_q;
	logic signed [COORD_WIDTH-1:0] older_x_q, older_y_q, newer_x_q, newer_y_q;
	logic                          tail_q;
	logic                          nx_neg_q, ny_neg_q;
	result_t                       res_q, out_q;
	logic                          out_valid_q;

	logic                          accept, out_free;
	logic signed [COORD_WIDTH-1:0] px, py;
	logic signed [MAG_WIDTH-1:0]   dx, dy;
	logic [MAG_WIDTH-1:0]          abs_dx, abs_dy;
	logic                          flat, start_mag;

	logic                          sq_done, rt_done, divx_done, divy_done;
	logic [SUM_WIDTH-1:0]          sq_sum;
	logic [NORM_BITS-1:0]          a_norm, b_norm;
	logic [ROOT_BITS-1:0]          root;
	logic [QUO_WIDTH-1:0]          quo_x, quo_y;

	function automatic logic [OUT_WIDTH-1:0] signed_comp(logic [QUO_WIDTH-1:0] q, logic neg);
		logic [QUO_WIDTH-1:0]     capped;
		logic [MAG_OUT_WIDTH-1:0] mag;
		if (neg) begin
			capped = (q > NEG_CAP) ? NEG_CAP : q;
		end else begin
			capped = (q > POS_CAP) ? POS_CAP : q;
		end
		mag = MAG_OUT_WIDTH'(capped);
		return neg ? OUT_WIDTH'(-mag) : OUT_WIDTH'(mag);
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign px     = s_tdata[COORD_WIDTH-1:0];
	assign py     = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
	assign dx     = MAG_WIDTH'(px) - MAG_WIDTH'(older_x_q);
	assign dy     = MAG_WIDTH'(py) - MAG_WIDTH'(older_y_q);
	assign abs_dx = dx[MAG_WIDTH-1] ? MAG_WIDTH'(-dx) : MAG_WIDTH'(dx);
	assign abs_dy = dy[MAG_WIDTH-1] ? MAG_WIDTH'(-dy) : MAG_WIDTH'(dy);
	assign flat   = (abs_dx == '0) && (abs_dy == '0);

	assign start_mag = accept && (seen_q == SEEN_TWO) && !flat;

	pnu_sqmag u_sqmag (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_mag),
		.a_in   (abs_dx),
		.b_in   (abs_dy),
		.done   (sq_done),
		.sum    (sq_sum),
		.a_norm (a_norm),
		.b_norm (b_norm)
	);

	pnu_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_done),
		.radicand (sq_sum),
		.done     (rt_done),
		.root     (root)
	);

	// normal_x comes from |dy|, normal_y from |dx|
	pnu_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rt_done),
		.mag    (b_norm),
		.len    (root),
		.done   (divx_done),
		.quo    (quo_x)
	);

	pnu_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rt_done),
		.mag    (a_norm),
		.len    (root),
		.done   (divy_done),
		.quo    (quo_y)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q  <= SEEN_NONE;
			tail_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (seen_q)
							SEEN_NONE: begin
								tail_q  <= 1'b0;
								state_q <= ST_EMIT;
								if (!s_tlast) begin
									seen_q <= SEEN_ONE;
								end
							end
							SEEN_ONE: begin
								tail_q <= 1'b0;
								if (s_tlast) begin
									seen_q  <= SEEN_NONE;
									state_q <= ST_EMIT;
								end else begin
									seen_q <= SEEN_TWO;
								end
							end
							default: begin
								tail_q  <= s_tlast;
								state_q <= flat ? ST_EMIT : ST_MAG;
								if (s_tlast) begin
									seen_q <= SEEN_NONE;
								end
							end
						endcase
					end
				end
				ST_MAG: begin
					if (sq_done) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (rt_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (divx_done && divy_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (tail_q) begin
							tail_q <= 1'b0;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// point history and pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_x_q <= '0;
			older_y_q <= '0;
			newer_x_q <= '0;
			newer_y_q <= '0;
		end else if (accept && !s_tlast) begin
			if (seen_q == SEEN_NONE) begin
				newer_x_q <= px;
				newer_y_q <= py;
			end else begin
				older_x_q <= newer_x_q;
				older_y_q <= newer_y_q;
				newer_x_q <= px;
				newer_y_q <= py;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			nx_neg_q <= !dy[MAG_WIDTH-1];
			ny_neg_q <= dx[MAG_WIDTH-1];
			if (seen_q == SEEN_TWO) begin
				res_q <= '{normal_x: '0, normal_y: '0, degenerate: 1'b1, last_normal: 1'b0};
			end else begin
				res_q <= '{normal_x: '0, normal_y: '0, degenerate: 1'b0,
					last_normal: s_tlast};
			end
		end else if (state_q == ST_DIV && divx_done && divy_done) begin
			res_q <= '{normal_x: signed_comp(quo_x, nx_neg_q),
				normal_y: signed_comp(quo_y, ny_neg_q), degenerate: 1'b0, last_normal: 1'b0};
		end else if (state_q == ST_EMIT && out_free && tail_q) begin
			res_q <= ZERO_LAST;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_WIDTH'({out_q.normal_y, out_q.normal_x});
	assign m_tuser  = out_q.degenerate;
	assign m_tlast  = out_q.last_normal;

endmodule

`default_nettype wire

// File: src/pnu_sqmag.sv
// Normalizes the difference magnitudes and forms a*a + b*b bit-serially.
`default_nettype none

module pnu_sqmag (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [pnu_pkg::MAG_WIDTH-1:0]    a_in,
	input  wire logic [pnu_pkg::MAG_WIDTH-1:0]    b_in,
	output logic                                  done,
	output logic [pnu_pkg::SUM_WIDTH-1:0]         sum,
	output logic [pnu_pkg::NORM_BITS-1:0]         a_norm,
	output logic [pnu_pkg::NORM_BITS-1:0]         b_norm
);
	import pnu_pkg::*;

	typedef enum logic [2:0] {
		SQ_IDLE = 3'b001,
		SQ_NORM = 3'b010,
		SQ_MUL  = 3'b100
	} sq_state_t;

	sq_state_t                state_q;
	logic [NIN_WIDTH-1:0]     a_q, b_q;
	logic [NIN_WIDTH-1:0]     ab_or;
	logic [SUM_WIDTH-1:0]     ma_q, mb_q, acc_q;
	logic [NORM_BITS-1:0]     ra_q, rb_q;
	logic [MUL_CNT_WIDTH-1:0] cnt_q;
	logic                     done_q;
	logic                     too_big;

	assign ab_or   = a_q | b_q;
	assign too_big = (ab_or >> NORM_BITS) != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				SQ_IDLE: begin
					if (start) begin
						state_q <= SQ_NORM;
					end
				end
				SQ_NORM: begin
					if (!too_big && ab_or[NORM_BITS-1]) begin
						state_q <= SQ_MUL;
					end
				end
				SQ_MUL: begin
					if (cnt_q == MUL_CNT_WIDTH'(NORM_BITS - 1)) begin
						state_q <= SQ_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= SQ_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SQ_IDLE: begin
				if (start) begin
					a_q <= NIN_WIDTH'(a_in);
					b_q <= NIN_WIDTH'(b_in);
				end
			end
			SQ_NORM: begin
				if (too_big) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
				end else if (!ab_or[NORM_BITS-1]) begin
					a_q <= a_q << 1;
					b_q <= b_q << 1;
				end else begin
					ma_q  <= SUM_WIDTH'(a_q[NORM_BITS-1:0]);
					mb_q  <= SUM_WIDTH'(b_q[NORM_BITS-1:0]);
					ra_q  <= a_q[NORM_BITS-1:0];
					rb_q  <= b_q[NORM_BITS-1:0];
					acc_q <= '0;
					cnt_q <= '0;
				end
			end
			SQ_MUL: begin
				// one multiplier bit of each square per cycle
				acc_q <= acc_q + (ra_q[0] ? ma_q : '0) + (rb_q[0] ? mb_q : '0);
				ma_q  <= ma_q << 1;
				mb_q  <= mb_q << 1;
				ra_q  <= ra_q >> 1;
				rb_q  <= rb_q >> 1;
				cnt_q <= cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign sum    = acc_q;
	assign a_norm = a_q[NORM_BITS-1:0];
	assign b_norm = b_q[NORM_BITS-1:0];

endmodule

`default_nettype wire

// File: src/pnu_isqrt.sv
// Restoring integer square root, one root bit per cycle.
`default_nettype none

module pnu_isqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [pnu_pkg::SUM_WIDTH-1:0] radicand,
	output logic                               done,
	output logic [pnu_pkg::ROOT_BITS-1:0]      root
);
	import pnu_pkg::*;

	logic [SQRT_WIDTH-1:0] s_q, r_q, bit_q;
	logic [SQRT_WIDTH-1:0] trial;
	logic                  busy_q, done_q;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			s_q   <= SQRT_WIDTH'(radicand);
			r_q   <= '0;
			bit_q <= SQRT_WIDTH'(1) << (SQRT_WIDTH - 2);
		end else if (busy_q) begin
			if (s_q >= trial) begin
				s_q <= s_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[ROOT_BITS-1:0];

endmodule

`default_nettype wire

// File: src/pnu_div.sv
// Restoring divider lane: rounded (mag << F) / len, one quotient bit per cycle.
`default_nettype none

module pnu_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [pnu_pkg::NORM_BITS-1:0] mag,
	input  wire logic [pnu_pkg::ROOT_BITS-1:0] len,
	output logic                               done,
	output logic [pnu_pkg::QUO_WIDTH-1:0]      quo
);
	import pnu_pkg::*;

	logic [DIV_WIDTH-1:0]     rem_q, dsr_q;
	logic [QUO_WIDTH-1:0]     quo_q;
	logic [DIV_CNT_WIDTH-1:0] cnt_q;
	logic                     busy_q, done_q;
	logic                     fits;

	assign fits = rem_q >= dsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == DIV_CNT_WIDTH'(QUO_WIDTH - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// half the divisor added up front rounds half up
			rem_q <= (DIV_WIDTH'(mag) << NORMAL_FRAC_BITS) + DIV_WIDTH'(len >> 1);
			dsr_q <= DIV_WIDTH'(len) << NORMAL_FRAC_BITS;
			quo_q <= '0;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsr_q;
			end
			quo_q <= {quo_q[QUO_WIDTH-2:0], fits};
			dsr_q <= dsr_q >> 1;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the polyline unit normal stream core.
`timescale 1ns / 100ps

module tb;
	import pnu_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 150;
	localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [S_TDATA_WIDTH-1:0] s_tdata;
	logic                     s_tlast;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [M_TDATA_WIDTH-1:0] m_tdata;
	logic                     m_tuser;
	logic                     m_tlast;

	// predictor copy of the point history
	logic signed [COORD_WIDTH-1:0] prev_x, prev_y, cur_x, cur_y;
	int                            held;

	result_t normal_q[$];
	result_t want;

	bit src_idle;
	bit sink_stall;
	int errors;
	int n_sent;
	int n_scans;
	int n_checked;
	int n_degenerate;
	int n_saturated;
	int quiet_cycles;

	polyline_unit_normal_stream_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	function automatic int idle_len();
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(20, 150);
		return $urandom_range(1, 4);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned rem, res, probe;
		rem   = v;
		res   = 0;
		probe = 64'h4000_0000_0000_0000;
		while (probe > rem)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rem >= res + probe) begin
				rem = rem - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return res;
	endfunction

	// rounded quotient in Q1.F, saturated, sign applied last
	function automatic logic signed [OUT_WIDTH-1:0] scaled_comp(longint unsigned m, bit neg,
			longint unsigned len);
		longint unsigned q;
		logic [OUT_WIDTH-1:0] mag;
		q = ((m << NORMAL_FRAC_BITS) + (len >> 1)) / len;
		if (neg && q > longint'(NEG_CAP_INT))
			q = NEG_CAP_INT;
		if (!neg && q > longint'(POS_CAP_INT))
			q = POS_CAP_INT;
		mag = q[OUT_WIDTH-1:0];
		return neg ? -mag : mag;
	endfunction

	function automatic result_t interior_normal(longint dx, longint dy);
		result_t r;
		longint unsigned a, b, big, len;
		r   = '0;
		a   = (dx < 0) ? -dx : dx;
		b   = (dy < 0) ? -dy : dy;
		big = (a > b) ? a : b;
		if (big == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		while (big >= (64'd1 << 31)) begin
			a   = a >> 1;
			b   = b >> 1;
			big = big >> 1;
		end
		while (big < (64'd1 << 30)) begin
			a   = a << 1;
			b   = b << 1;
			big = big << 1;
		end
		len = int_sqrt(a * a + b * b);
		r.normal_x = scaled_comp(b, dy >= 0, len);
		r.normal_y = scaled_comp(a, dx < 0, len);
		return r;
	endfunction

	function automatic result_t flat_normal(bit last);
		result_t r;
		r = '0;
		r.last_normal = last;
		return r;
	endfunction

	// append one predicted normal at the tail of the queue
	task automatic queue_normal(result_t r);
		normal_q.insert(normal_q.size(), r);
	endtask

	task automatic predict_point(logic signed [COORD_WIDTH-1:0] x, logic signed [COORD_WIDTH-1:0] y,
			bit last);
		case (held)
			0: begin
				queue_normal(flat_normal(last));
				if (!last) begin
					cur_x = x;
					cur_y = y;
					held  = 1;
				end
			end
			1: begin
				if (last) begin
					queue_normal(flat_normal(1'b1));
					held = 0;
				end else begin
					prev_x = cur_x;
					prev_y = cur_y;
					cur_x  = x;
					cur_y  = y;
					held   = 2;
				end
			end
			default: begin
				queue_normal(interior_normal(longint'(x) - longint'(prev_x),
					longint'(y) - longint'(prev_y)));
				if (last) begin
					queue_normal(flat_normal(1'b1));
					held = 0;
				end else begin
					prev_x = cur_x;
					prev_y = cur_y;
					cur_x  = x;
					cur_y  = y;
				end
			end
		endcase
	endtask

	task automatic check_field(string name, logic signed [31:0] exp_val,
			logic signed [31:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
			errors++;
		end
	endtask

	// input transfers feed the predictor
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			predict_point(s_tdata[COORD_WIDTH-1:0], s_tdata[2*COORD_WIDTH-1:COORD_WIDTH], s_tlast);
	end

	// output transfers are checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (normal_q.size() == 0) begin
				$display("%0t: unexpected normal, tdata %h tuser %b tlast %b", $time, m_tdata,
					m_tuser, m_tlast);
				errors++;
			end else begin
				want = normal_q.pop_front();
				check_field("normal_x", want.normal_x, $signed(m_tdata[OUT_WIDTH-1:0]));
				check_field("normal_y", want.normal_y, $signed(m_tdata[2*OUT_WIDTH-1:OUT_WIDTH]));
				check_field("degenerate", want.degenerate, m_tuser);
				check_field("last_normal", want.last_normal, m_tlast);
				n_checked++;
				if (want.degenerate)
					n_degenerate++;
				if (want.normal_x == POS_CAP_INT || want.normal_x == -NEG_CAP_INT ||
						want.normal_y == POS_CAP_INT || want.normal_y == -NEG_CAP_INT)
					n_saturated++;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d normals outstanding", $time,
					quiet_cycles, normal_q.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// result sink with random back-pressure
	initial begin
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			if (sink_stall && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat (idle_len()) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic send_point(logic signed [COORD_WIDTH-1:0] x, logic signed [COORD_WIDTH-1:0] y,
			bit last);
		if (src_idle && $urandom_range(0, 2) == 0) begin
			s_tvalid <= 1'b0;
			repeat (idle_len()) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {y, x};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		n_sent++;
		if (last)
			n_scans++;
	endtask

	// hold input off until every predicted normal has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (normal_q.size() != 0);
	endtask

	function automatic logic signed [COORD_WIDTH-1:0] next_coord(int mode,
			logic signed [COORD_WIDTH-1:0] last_val);
		case (mode)
			0: return COORD_WIDTH'($urandom());
			1: return COORD_WIDTH'(last_val + $signed($urandom_range(0, 64)) - 32);
			2: return COORD_WIDTH'($signed($urandom_range(0, 2)) - 1);
			3: begin
				case ($urandom_range(0, 4))
					0: return CMIN;
					1: return CMAX;
					2: return '0;
					3: return '1;
					default: return COORD_WIDTH'(1);
				endcase
			end
			default: return COORD_WIDTH'(last_val + $signed($urandom_range(0, 1 << 21)) -
				(1 << 20));
		endcase
	endfunction

	function automatic int scan_length();
		case ($urandom_range(0, 19))
			0: return 1;
			1: return 2;
			2: return $urandom_range(25, 80);
			default: return $urandom_range(3, 24);
		endcase
	endfunction

	task automatic test_edge_scans();
		src_idle   = 1'b0;
		sink_stall = 1'b0;
		// one-point scan
		send_point(CMAX, CMIN, 1'b1);
		// two-point scan
		send_point(CMIN, CMIN, 1'b0);
		send_point(CMAX, CMAX, 1'b1);
		// widest neighbor differences
		send_point(CMIN, CMAX, 1'b0);
		send_point(0, 0, 1'b0);
		send_point(CMAX, CMIN, 1'b0);
		send_point(CMIN, CMIN, 1'b1);
		// neighbors coincide: zero-length difference
		send_point(5, 7, 1'b0);
		send_point(100, -3, 1'b0);
		send_point(5, 7, 1'b0);
		send_point(-1, -1, 1'b1);
		// axis-aligned steps hit both saturation limits
		send_point(-1, 0, 1'b0);
		send_point(0, 5, 1'b0);
		send_point(1, 0, 1'b0);
		send_point(0, -1, 1'b0);
		send_point(-1, 0, 1'b0);
		send_point(0, 3, 1'b1);
		// long step with a tiny cross component
		send_point(CMIN, 0, 1'b0);
		send_point(0, 0, 1'b0);
		send_point(CMAX, 1, 1'b1);
	endtask

	task automatic test_pause_mid_scan();
		src_idle   = 1'b1;
		sink_stall = 1'b1;
		send_point(10, 20, 1'b0);
		wait_drained();
		send_point(-300, 40, 1'b0);
		wait_drained();
		send_point(77, -5000, 1'b0);
		wait_drained();
		send_point(1234, 999, 1'b0);
		wait_drained();
		send_point(-8, -8, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_scans(int n_points, bit idle, bit pauses);
		int total, len, mode, i;
		logic signed [COORD_WIDTH-1:0] x, y;
		src_idle   = idle;
		sink_stall = idle;
		total      = 0;
		while (total < n_points) begin
			len  = scan_length();
			mode = $urandom_range(0, 4);
			x    = COORD_WIDTH'($urandom());
			y    = COORD_WIDTH'($urandom());
			for (i = 0; i < len; i++) begin
				x = next_coord(mode, x);
				y = next_coord(mode, y);
				if (pauses && $urandom_range(0, 39) == 0)
					wait_drained();
				send_point(x, y, i == len - 1);
			end
			total += len;
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		held     = 0;
		prev_x   = '0;
		prev_y   = '0;
		cur_x    = '0;
		cur_y    = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_scans();
		test_pause_mid_scan();
		test_random_scans(600, 1'b0, 1'b0);
		test_random_scans(1000, 1'b1, 1'b1);
		test_random_scans(300, 1'b0, 1'b1);

		s_tvalid <= 1'b0;
		do @(posedge clk); while (normal_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Streamed %0d points in %0d scans; %0d normals checked", n_sent, n_scans,
			n_checked);
		$display("of which %0d degenerate and %0d with a saturated component", n_degenerate,
			n_saturated);
		if (errors == 0 && normal_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: polyline_unit_normal_stream_core.f
src/pnu_pkg.sv
src/pnu_sqmag.sv
src/pnu_isqrt.sv
src/pnu_div.sv
src/polyline_unit_normal_stream_core.sv
dv/tb.sv
